// File: hw/rtl/eeu_pkg.sv
// eeu_pkg: types, codes and constants shared by the exception entry unit.
// Used by eeu_syndrome, eeu_core and exception_entry_unit.
// Has no dependencies of its own.
package eeu_pkg;

   // operation codes
   localparam logic [1:0] OP_RAISE     = 2'd0;
   localparam logic [1:0] OP_TAKE      = 2'd1;
   localparam logic [1:0] OP_SET_LEVEL = 2'd2;

   // exception kinds
   localparam logic [3:0] KIND_NONE     = 4'd0;
   localparam logic [3:0] KIND_UNDEF    = 4'd1;
   localparam logic [3:0] KIND_PRIV     = 4'd2;
   localparam logic [3:0] KIND_SYSREG   = 4'd3;
   localparam logic [3:0] KIND_IABT     = 4'd4;
   localparam logic [3:0] KIND_DABT     = 4'd5;
   localparam logic [3:0] KIND_TRANSL   = 4'd6;
   localparam logic [3:0] KIND_PERM     = 4'd7;
   localparam logic [3:0] KIND_ALIGN    = 4'd8;
   localparam logic [3:0] KIND_SP_ALIGN = 4'd9;
   localparam logic [3:0] KIND_TIMER    = 4'd10;
   localparam logic [3:0] KIND_IRQ      = 4'd11;
   localparam logic [3:0] KIND_FIQ      = 4'd12;

   // exception classes
   localparam logic [5:0] EC_UNKNOWN    = 6'h00;
   localparam logic [5:0] EC_SYSREG     = 6'h18;
   localparam logic [5:0] EC_IABT_LOWER = 6'h20;
   localparam logic [5:0] EC_IABT_SAME  = 6'h21;
   localparam logic [5:0] EC_PC_ALIGN   = 6'h22;
   localparam logic [5:0] EC_DABT_LOWER = 6'h24;
   localparam logic [5:0] EC_DABT_SAME  = 6'h25;
   localparam logic [5:0] EC_SP_ALIGN   = 6'h26;

   // fault status codes
   localparam logic [5:0] FSC_TRANSL_L3 = 6'h07;
   localparam logic [5:0] FSC_PERM_L3   = 6'h0f;
   localparam logic [5:0] FSC_ALIGN     = 6'h21;

   // syndrome bits and instruction decode patterns
   localparam logic [31:0] IL_BIT         = 32'h0200_0000;
   localparam logic [31:0] WNR_BIT        = 32'h0000_0040;
   localparam logic [31:0] ISS_MASK       = 32'h01ff_ffff;
   localparam logic [31:0] LDST_PAIR_MASK = 32'h3e00_0000;
   localparam logic [31:0] LDST_PAIR_VAL  = 32'h2800_0000;
   localparam logic [31:0] PAIR_LOAD_BIT  = 32'h0040_0000;
   localparam logic [31:0] UIMM_MASK      = 32'h3f00_0000;
   localparam logic [31:0] UIMM_VAL       = 32'h3900_0000;
   localparam logic [31:0] UNSC_MASK      = 32'h3f20_0c00;
   localparam logic [31:0] UNSC_VAL       = 32'h3800_0000;
   localparam logic [31:0] REGOFF_VAL     = 32'h3820_0800;
   localparam logic [31:0] OPC_MASK       = 32'h00c0_0000;

   // pstate fields
   localparam logic [31:0] MODE_MASK = 32'h0000_000f;
   localparam logic [31:0] DAIF_MASK = 32'h0000_03c0;

   // vector table layout
   localparam logic [63:0] VBAR_LOW_MASK = 64'h0000_0000_0000_07ff;
   localparam logic [63:0] VEC_LOWER     = 64'h400;
   localparam logic [63:0] VEC_SPX       = 64'h200;
   localparam logic [63:0] VEC_IRQ_SLOT  = 64'h080;
   localparam logic [63:0] VEC_FIQ_SLOT  = 64'h100;

   // configuration register indexes
   localparam logic [1:0] CSR_VBAR_EL1 = 2'd0;
   localparam logic [1:0] CSR_VBAR_EL2 = 2'd1;
   localparam logic [1:0] CSR_VBAR_EL3 = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  kind;
      logic [63:0] pc;
      logic [63:0] fault_address;
      logic [31:0] syndrome_in;
      logic [31:0] instruction;
      logic [1:0]  new_level;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [1:0]  target_level;
      logic [31:0] syndrome;
      logic [63:0] vector_address;
      logic [31:0] pstate_out;
      logic [63:0] link_address;
      logic [31:0] esr_out;
      logic [63:0] far_out;
      logic [1:0]  level_out;
   } rsp_type;

   typedef struct packed {
      logic [63:0] vbar_el1;
      logic [63:0] vbar_el2;
      logic [63:0] vbar_el3;
   } csr_type;

   // mode field for an exception level (SPx selected above EL0)
   function automatic logic [31:0] mode_of(input logic [1:0] el);
      logic [31:0] mode;
      unique case (el)
         2'd0:    mode = 32'd0;
         2'd1:    mode = 32'd5;
         2'd2:    mode = 32'd9;
         default: mode = 32'd13;
      endcase
      return mode;
   endfunction

endpackage

// File: hw/rtl/exception_entry_unit.sv
// exception_entry_unit: top level with request/result registers and the
// vector base register port. Depends on eeu_pkg and eeu_core.
//
// Usage
//   Requests (raise, take, set level) enter on the req_ valid/ready channel;
//   each produces exactly one result on the rsp_ valid/ready channel, in order.
//   Vector base registers for EL1..EL3 sit on an APB-style port at byte
//   addresses 0x0, 0x8 and 0x10, 64 bits wide; the low 11 bits read as zero.
//   Writes are taken on the access cycle; pready is tied high.
// Throughput
//   A request waits in the request register, then moves with its state
//   update into the result register. One request per cycle is sustained
//   while rsp_ready stays high; the rate is set by the single state update
//   pass between the request register and the result register.
// Reset
//   Synchronous, active high. Clears current level, pstate, the pending
//   record, all SPSR/ELR/ESR/FAR banks, the last vector and the vector bases.
// Stalls
//   When rsp_ready is low the result register holds and one more request
//   waits in the request register; req_ready then drops until the result
//   is taken.
module exception_entry_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_kind,
   input  logic [63:0] req_pc,
   input  logic [63:0] req_fault_address,
   input  logic [31:0] req_syndrome_in,
   input  logic [31:0] req_instruction,
   input  logic [1:0]  req_new_level,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [1:0]  rsp_target_level,
   output logic [31:0] rsp_syndrome,
   output logic [63:0] rsp_vector_address,
   output logic [31:0] rsp_pstate_out,
   output logic [63:0] rsp_link_address,
   output logic [31:0] rsp_esr_out,
   output logic [63:0] rsp_far_out,
   output logic [1:0]  rsp_level_out,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   eeu_pkg::req_type req_ff, req_in;
   logic             req_valid_ff;
   eeu_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff;
   eeu_pkg::csr_type csr_ff;
   logic             fire;
   logic             csr_write;
   logic [1:0]       csr_index;

   // request moves into the result register when that slot is free
   assign fire      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || fire;

   always_comb begin
      req_in.op            = req_op;
      req_in.kind          = req_kind;
      req_in.pc            = req_pc;
      req_in.fault_address = req_fault_address;
      req_in.syndrome_in   = req_syndrome_in;
      req_in.instruction   = req_instruction;
      req_in.new_level     = req_new_level;
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_in;
      end
   end

   eeu_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_ff),
      .csr   (csr_ff),
      .rsp   (rsp_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_target_level   = rsp_ff.target_level;
   assign rsp_syndrome       = rsp_ff.syndrome;
   assign rsp_vector_address = rsp_ff.vector_address;
   assign rsp_pstate_out     = rsp_ff.pstate_out;
   assign rsp_link_address   = rsp_ff.link_address;
   assign rsp_esr_out        = rsp_ff.esr_out;
   assign rsp_far_out        = rsp_ff.far_out;
   assign rsp_level_out      = rsp_ff.level_out;

   // vector base registers
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:3];
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            eeu_pkg::CSR_VBAR_EL1: csr_ff.vbar_el1 <= pwdata & ~eeu_pkg::VBAR_LOW_MASK;
            eeu_pkg::CSR_VBAR_EL2: csr_ff.vbar_el2 <= pwdata & ~eeu_pkg::VBAR_LOW_MASK;
            eeu_pkg::CSR_VBAR_EL3: csr_ff.vbar_el3 <= pwdata & ~eeu_pkg::VBAR_LOW_MASK;
            default: ;
         endcase
      end
   end

   // register read
   always_comb begin
      unique case (csr_index)
         eeu_pkg::CSR_VBAR_EL1: prdata = csr_ff.vbar_el1;
         eeu_pkg::CSR_VBAR_EL2: prdata = csr_ff.vbar_el2;
         eeu_pkg::CSR_VBAR_EL3: prdata = csr_ff.vbar_el3;
         default:               prdata = 64'd0;
      endcase
   end

endmodule

// File: hw/rtl/eeu_syndrome.sv
// eeu_syndrome: builds the ESR value for a raised exception from its kind.
// Purely combinational; depends on eeu_pkg for kinds, classes and patterns.
module eeu_syndrome (
   input  logic [3:0]  kind,
   input  logic [1:0]  level,
   input  logic [1:0]  pc_low,
   input  logic [31:0] instruction,
   output logic [31:0] syndrome
);

   logic        lower;
   logic [5:0]  dabt_ec;
   logic [1:0]  sz;
   logic [1:0]  opc;
   logic        pair_hit;
   logic        single_hit;
   logic        size_ok;
   logic [31:0] extra;

   assign lower   = (level == 2'd0);
   assign dabt_ec = lower ? eeu_pkg::EC_DABT_LOWER : eeu_pkg::EC_DABT_SAME;
   assign sz      = instruction[31:30];
   assign opc     = instruction[23:22];

   // load/store decode for the data abort ISS
   assign pair_hit = ((instruction & eeu_pkg::LDST_PAIR_MASK) == eeu_pkg::LDST_PAIR_VAL);
   assign size_ok  = ((sz != 2'd3) || (opc[1] == 1'b0)) && !((sz == 2'd2) && (opc == 2'd3));
   assign single_hit =
      (((instruction & eeu_pkg::UIMM_MASK) == eeu_pkg::UIMM_VAL) ||
       ((instruction & eeu_pkg::UNSC_MASK) == eeu_pkg::UNSC_VAL) ||
       (((instruction & eeu_pkg::UNSC_MASK) == eeu_pkg::REGOFF_VAL) && instruction[14]))
      && size_ok;

   // single register form wins over the pair form
   always_comb begin
      extra = 32'd0;
      if (pair_hit) begin
         extra = eeu_pkg::IL_BIT;
         if ((instruction & eeu_pkg::PAIR_LOAD_BIT) == 32'd0) begin
            extra = extra | eeu_pkg::WNR_BIT;
         end
      end
      if (single_hit) begin
         extra = eeu_pkg::IL_BIT;
         if ((instruction & eeu_pkg::OPC_MASK) == 32'd0) begin
            extra = extra | eeu_pkg::WNR_BIT;
         end
      end
   end

   // class and status per kind
   always_comb begin
      unique case (kind)
         eeu_pkg::KIND_SYSREG: begin
            syndrome = {eeu_pkg::EC_SYSREG, 26'd0} | (instruction & eeu_pkg::ISS_MASK);
         end
         eeu_pkg::KIND_IABT: begin
            if (pc_low != 2'd0) begin
               syndrome = {eeu_pkg::EC_PC_ALIGN, 26'd0};
            end else begin
               syndrome = {(lower ? eeu_pkg::EC_IABT_LOWER : eeu_pkg::EC_IABT_SAME), 26'd0}
                          | {26'd0, eeu_pkg::FSC_TRANSL_L3};
            end
         end
         eeu_pkg::KIND_DABT: begin
            syndrome = {dabt_ec, 26'd0} | extra | {26'd0, eeu_pkg::FSC_TRANSL_L3};
         end
         eeu_pkg::KIND_TRANSL: begin
            syndrome = {dabt_ec, 26'd0} | {26'd0, eeu_pkg::FSC_TRANSL_L3};
         end
         eeu_pkg::KIND_PERM: begin
            syndrome = {dabt_ec, 26'd0} | {26'd0, eeu_pkg::FSC_PERM_L3};
         end
         eeu_pkg::KIND_ALIGN: begin
            syndrome = {dabt_ec, 26'd0} | extra | {26'd0, eeu_pkg::FSC_ALIGN};
         end
         eeu_pkg::KIND_SP_ALIGN: begin
            syndrome = {eeu_pkg::EC_SP_ALIGN, 26'd0} | eeu_pkg::IL_BIT;
         end
         eeu_pkg::KIND_UNDEF, eeu_pkg::KIND_PRIV: begin
            syndrome = {eeu_pkg::EC_UNKNOWN, 26'd0} | eeu_pkg::IL_BIT;
         end
         default: begin
            syndrome = 32'd0;
         end
      endcase
   end

endmodule

// File: hw/rtl/eeu_core.sv
// eeu_core: architectural state of the exception unit and the one-pass
// update for a request. Depends on eeu_pkg and eeu_syndrome.
module eeu_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  eeu_pkg::req_type req,
   input  eeu_pkg::csr_type csr,
   output eeu_pkg::rsp_type rsp
);

   logic [1:0]  current_level_ff, current_level_in;
   logic [31:0] pstate_ff, pstate_in;
   logic [3:0]  pending_kind_ff, pending_kind_in;
   logic [1:0]  pending_target_ff, pending_target_in;
   logic        from_lower_ff, from_lower_in;
   logic [63:0] last_vector_ff, last_vector_in;
   logic [31:0] spsr_ff [4];
   logic [31:0] spsr_in [4];
   logic [63:0] elr_ff  [4];
   logic [63:0] elr_in  [4];
   logic [31:0] esr_ff  [4];
   logic [31:0] esr_in  [4];
   logic [63:0] far_ff  [4];
   logic [63:0] far_in  [4];

   logic [31:0] built_syndrome;
   logic [1:0]  raise_target;
   logic        kind_bad;
   logic        kind_async;
   logic [63:0] take_base;
   logic [63:0] take_offset;
   logic [1:0]  tgt;
   logic        status;
   logic [31:0] syn;

   eeu_syndrome u_syndrome (
      .kind        (req.kind),
      .level       (current_level_ff),
      .pc_low      (req.pc[1:0]),
      .instruction (req.instruction),
      .syndrome    (built_syndrome)
   );

   assign raise_target = (current_level_ff == 2'd0) ? 2'd1 : current_level_ff;
   assign kind_bad     = (req.kind == eeu_pkg::KIND_NONE) || (req.kind > eeu_pkg::KIND_FIQ);
   assign kind_async   = (req.kind == eeu_pkg::KIND_TIMER) || (req.kind == eeu_pkg::KIND_IRQ)
                         || (req.kind == eeu_pkg::KIND_FIQ);

   // vector base of the pending target; level zero has none
   always_comb begin
      unique case (pending_target_ff)
         2'd1:    take_base = csr.vbar_el1;
         2'd2:    take_base = csr.vbar_el2;
         2'd3:    take_base = csr.vbar_el3;
         default: take_base = 64'd0;
      endcase
   end

   // vector offset: lower / current SPx / current SP0, then the interrupt slot
   always_comb begin
      if (from_lower_ff) begin
         take_offset = eeu_pkg::VEC_LOWER;
      end else if (spsr_ff[pending_target_ff][0]) begin
         take_offset = eeu_pkg::VEC_SPX;
      end else begin
         take_offset = 64'd0;
      end
      if ((pending_kind_ff == eeu_pkg::KIND_TIMER) || (pending_kind_ff == eeu_pkg::KIND_IRQ)) begin
         take_offset = take_offset + eeu_pkg::VEC_IRQ_SLOT;
      end else if (pending_kind_ff == eeu_pkg::KIND_FIQ) begin
         take_offset = take_offset + eeu_pkg::VEC_FIQ_SLOT;
      end
   end

   // next state for the request in flight
   always_comb begin
      current_level_in  = current_level_ff;
      pstate_in         = pstate_ff;
      pending_kind_in   = pending_kind_ff;
      pending_target_in = pending_target_ff;
      from_lower_in     = from_lower_ff;
      last_vector_in    = last_vector_ff;
      spsr_in           = spsr_ff;
      elr_in            = elr_ff;
      esr_in            = esr_ff;
      far_in            = far_ff;
      status            = 1'b0;
      syn               = 32'd0;
      tgt               = current_level_ff;
      unique case (req.op)
         eeu_pkg::OP_RAISE: begin
            tgt = raise_target;
            if (kind_bad || (pending_kind_ff != eeu_pkg::KIND_NONE)) begin
               status = 1'b1;
            end else begin
               syn               = (req.syndrome_in != 32'd0) ? req.syndrome_in : built_syndrome;
               pending_kind_in   = req.kind;
               pending_target_in = raise_target;
               from_lower_in     = (current_level_ff < raise_target);
               spsr_in[raise_target] = pstate_ff;
               elr_in[raise_target]  = req.pc;
               if (!kind_async) begin
                  esr_in[raise_target] = syn;
                  far_in[raise_target] = req.fault_address;
               end
            end
         end
         eeu_pkg::OP_TAKE: begin
            tgt = pending_target_ff;
            if (pending_kind_ff == eeu_pkg::KIND_NONE) begin
               status = 1'b1;
            end else begin
               last_vector_in    = (take_base & ~eeu_pkg::VBAR_LOW_MASK) + take_offset;
               current_level_in  = pending_target_ff;
               pstate_in         = (spsr_ff[pending_target_ff] & ~eeu_pkg::MODE_MASK)
                                   | eeu_pkg::mode_of(pending_target_ff) | eeu_pkg::DAIF_MASK;
               pending_kind_in   = eeu_pkg::KIND_NONE;
               pending_target_in = 2'd0;
               from_lower_in     = 1'b0;
            end
         end
         eeu_pkg::OP_SET_LEVEL: begin
            tgt              = req.new_level;
            current_level_in = req.new_level;
            pstate_in        = (pstate_ff & ~eeu_pkg::MODE_MASK) | eeu_pkg::mode_of(req.new_level);
         end
         default: begin
            status = 1'b1;
         end
      endcase
   end

   // result reflects the state after the update
   always_comb begin
      rsp.status         = status;
      rsp.target_level   = tgt;
      rsp.syndrome       = syn;
      rsp.vector_address = last_vector_in;
      rsp.pstate_out     = pstate_in;
      rsp.link_address   = elr_in[tgt];
      rsp.esr_out        = esr_in[tgt];
      rsp.far_out        = far_in[tgt];
      rsp.level_out      = current_level_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         current_level_ff  <= 2'd0;
         pstate_ff         <= 32'd0;
         pending_kind_ff   <= eeu_pkg::KIND_NONE;
         pending_target_ff <= 2'd0;
         from_lower_ff     <= 1'b0;
         last_vector_ff    <= 64'd0;
         for (int i = 0; i < 4; i++) begin
            spsr_ff[i] <= 32'd0;
            elr_ff[i]  <= 64'd0;
            esr_ff[i]  <= 32'd0;
            far_ff[i]  <= 64'd0;
         end
      end else if (fire) begin
         current_level_ff  <= current_level_in;
         pstate_ff         <= pstate_in;
         pending_kind_ff   <= pending_kind_in;
         pending_target_ff <= pending_target_in;
         from_lower_ff     <= from_lower_in;
         last_vector_ff    <= last_vector_in;
         spsr_ff           <= spsr_in;
         elr_ff            <= elr_in;
         esr_ff            <= esr_in;
         far_ff            <= far_in;
      end
   end

endmodule

// File: dv/eeu_checker.sv
`timescale 1ns / 1ps
// eeu_checker: tracks accepted requests and vector base writes, predicts each
// result of exception_entry_unit and compares it with the result channel.
// Depends on eeu_pkg for the request/result types, codes and constants.
module eeu_checker
   import eeu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_kind,
   input  logic [63:0] req_pc,
   input  logic [63:0] req_fault_address,
   input  logic [31:0] req_syndrome_in,
   input  logic [31:0] req_instruction,
   input  logic [1:0]  req_new_level,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_status,
   input  logic [1:0]  rsp_target_level,
   input  logic [31:0] rsp_syndrome,
   input  logic [63:0] rsp_vector_address,
   input  logic [31:0] rsp_pstate_out,
   input  logic [63:0] rsp_link_address,
   input  logic [31:0] rsp_esr_out,
   input  logic [63:0] rsp_far_out,
   input  logic [1:0]  rsp_level_out,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,

   output int unsigned mismatch_count,
   output int unsigned results_owed
);

   // shadow copy of the unit's architectural state
   logic [63:0] vbar [4];
   logic [1:0]  cur_level;
   logic [31:0] pstate_q;
   logic [3:0]  pend_kind;
   logic [1:0]  pend_target;
   logic        pend_lower;
   logic [31:0] spsr_q [4];
   logic [63:0] elr_q  [4];
   logic [31:0] esr_q  [4];
   logic [63:0] far_q  [4];
   logic [63:0] last_vector;

   rsp_type     outcome_q [$];
   int unsigned errors = 0;
   req_type     req_seen;
   rsp_type     rsp_seen;

   assign mismatch_count = errors;
   assign req_seen = {req_op, req_kind, req_pc, req_fault_address, req_syndrome_in,
                      req_instruction, req_new_level};
   assign rsp_seen = {rsp_status, rsp_target_level, rsp_syndrome, rsp_vector_address,
                      rsp_pstate_out, rsp_link_address, rsp_esr_out, rsp_far_out,
                      rsp_level_out};

   // mode field: spx flavor above el0
   function automatic logic [31:0] level_mode(input logic [1:0] el);
      return (el == 2'd0) ? 32'd0 : {28'd0, el, 2'b01};
   endfunction

   // esr built from the kind, the level, pc alignment and load/store decode
   function automatic logic [31:0] form_syndrome(input logic [3:0] kind,
                                                 input logic [1:0] el,
                                                 input logic [63:0] pc,
                                                 input logic [31:0] ins);
      logic [5:0]  abort_ec;
      logic [5:0]  fetch_ec;
      logic [31:0] ls_bits;
      logic [31:0] syn;
      logic [1:0]  sz;
      logic [1:0]  opc;
      logic        single;
      abort_ec = (el == 2'd0) ? EC_DABT_LOWER : EC_DABT_SAME;
      fetch_ec = (el == 2'd0) ? EC_IABT_LOWER : EC_IABT_SAME;
      sz = ins[31:30];
      opc = ins[23:22];
      ls_bits = '0;
      // pair forms: write-not-read from the load bit
      if ((ins & LDST_PAIR_MASK) == LDST_PAIR_VAL)
         ls_bits = IL_BIT | (((ins & PAIR_LOAD_BIT) == '0) ? WNR_BIT : '0);
      // single register forms, minus the prefetch and unallocated encodings
      single = ((ins & UIMM_MASK) == UIMM_VAL) || ((ins & UNSC_MASK) == UNSC_VAL) ||
               (((ins & UNSC_MASK) == REGOFF_VAL) && ins[14]);
      if (single && (sz != 2'd3 || opc[1] == 1'b0) && !(sz == 2'd2 && opc == 2'd3))
         ls_bits = IL_BIT | (((ins & OPC_MASK) == '0) ? WNR_BIT : '0);
      case (kind)
         KIND_SYSREG: syn = {EC_SYSREG, 26'd0} | (ins & ISS_MASK);
         KIND_IABT: begin
            if (pc[1:0] != 2'd0) syn = {EC_PC_ALIGN, 26'd0};
            else syn = {fetch_ec, 26'd0} | 32'(FSC_TRANSL_L3);
         end
         KIND_DABT:             syn = {abort_ec, 26'd0} | ls_bits | 32'(FSC_TRANSL_L3);
         KIND_TRANSL:           syn = {abort_ec, 26'd0} | 32'(FSC_TRANSL_L3);
         KIND_PERM:             syn = {abort_ec, 26'd0} | 32'(FSC_PERM_L3);
         KIND_ALIGN:            syn = {abort_ec, 26'd0} | ls_bits | 32'(FSC_ALIGN);
         KIND_SP_ALIGN:         syn = {EC_SP_ALIGN, 26'd0} | IL_BIT;
         KIND_UNDEF, KIND_PRIV: syn = {EC_UNKNOWN, 26'd0} | IL_BIT;
         default:               syn = '0;
      endcase
      return syn;
   endfunction

   // apply one request to the shadow state and form its result
   function automatic rsp_type exception_outcome(input req_type r);
      rsp_type     o;
      logic [1:0]  tgt;
      logic [31:0] syn;
      logic        rejected;
      logic [63:0] slot;
      rejected = 1'b0;
      tgt = cur_level;
      syn = '0;
      case (r.op)
         OP_RAISE: begin
            tgt = (cur_level == 2'd0) ? 2'd1 : cur_level;
            if (r.kind == KIND_NONE || r.kind > KIND_FIQ || pend_kind != KIND_NONE) begin
               rejected = 1'b1;
            end else begin
               syn = (r.syndrome_in != '0) ? r.syndrome_in
                   : form_syndrome(r.kind, cur_level, r.pc, r.instruction);
               pend_kind = r.kind;
               pend_target = tgt;
               pend_lower = (cur_level < tgt);
               spsr_q[tgt] = pstate_q;
               elr_q[tgt] = r.pc;
               // interrupts leave esr and far untouched
               if (!(r.kind == KIND_TIMER || r.kind == KIND_IRQ || r.kind == KIND_FIQ)) begin
                  esr_q[tgt] = syn;
                  far_q[tgt] = r.fault_address;
               end
            end
         end
         OP_TAKE: begin
            tgt = pend_target;
            if (pend_kind == KIND_NONE) begin
               rejected = 1'b1;
            end else begin
               // table quadrant, then the interrupt slot
               if (pend_lower) slot = VEC_LOWER;
               else if (spsr_q[tgt][0]) slot = VEC_SPX;
               else slot = '0;
               if (pend_kind == KIND_TIMER || pend_kind == KIND_IRQ) slot += VEC_IRQ_SLOT;
               else if (pend_kind == KIND_FIQ) slot += VEC_FIQ_SLOT;
               last_vector = (vbar[tgt] & ~VBAR_LOW_MASK) + slot;
               cur_level = tgt;
               pstate_q = (spsr_q[tgt] & ~MODE_MASK) | level_mode(tgt) | DAIF_MASK;
               pend_kind = KIND_NONE;
               pend_target = '0;
               pend_lower = 1'b0;
            end
         end
         OP_SET_LEVEL: begin
            tgt = r.new_level;
            cur_level = r.new_level;
            pstate_q = (pstate_q & ~MODE_MASK) | level_mode(r.new_level);
         end
         default: rejected = 1'b1;
      endcase
      o.status = rejected;
      o.target_level = tgt;
      o.syndrome = syn;
      o.vector_address = last_vector;
      o.pstate_out = pstate_q;
      o.link_address = elr_q[tgt];
      o.esr_out = esr_q[tgt];
      o.far_out = far_q[tgt];
      o.level_out = cur_level;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // watch both channels and the register port
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            vbar[i] = '0;
            spsr_q[i] = '0;
            elr_q[i] = '0;
            esr_q[i] = '0;
            far_q[i] = '0;
         end
         cur_level = '0;
         pstate_q = '0;
         pend_kind = KIND_NONE;
         pend_target = '0;
         pend_lower = 1'b0;
         last_vector = '0;
         outcome_q.delete();
      end else begin
         // vector base writes, low bits dropped
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
               CSR_VBAR_EL1: vbar[1] = pwdata & ~VBAR_LOW_MASK;
               CSR_VBAR_EL2: vbar[2] = pwdata & ~VBAR_LOW_MASK;
               CSR_VBAR_EL3: vbar[3] = pwdata & ~VBAR_LOW_MASK;
               default: ;
            endcase
         end
         if (req_valid && req_ready) outcome_q.push_back(exception_outcome(req_seen));
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: result with no request outstanding, actual %h", $time,
                        rsp_seen);
               errors++;
            end else begin
               want = outcome_q.pop_front();
               check_field("status", want.status, rsp_seen.status);
               check_field("target_level", want.target_level, rsp_seen.target_level);
               check_field("syndrome", want.syndrome, rsp_seen.syndrome);
               check_field("vector_address", want.vector_address, rsp_seen.vector_address);
               check_field("pstate_out", want.pstate_out, rsp_seen.pstate_out);
               check_field("link_address", want.link_address, rsp_seen.link_address);
               check_field("esr_out", want.esr_out, rsp_seen.esr_out);
               check_field("far_out", want.far_out, rsp_seen.far_out);
               check_field("level_out", want.level_out, rsp_seen.level_out);
            end
         end
      end
      results_owed <= outcome_q.size();
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: clock, reset, request stimulus, result back-pressure and vector
// base writes for exception_entry_unit; gives the verdict.
// Depends on eeu_pkg, exception_entry_unit and eeu_checker.
module tb_top;
   import eeu_pkg::*;

   localparam int unsigned QUIET_LIMIT  = 200;
   localparam int unsigned RANDOM_ITEMS = 1600;
   localparam int unsigned PHASES       = 5;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam logic [3:0]  KIND_BAD_LOW  = 4'd13;
   localparam logic [3:0]  KIND_BAD_HIGH = 4'd15;
   localparam logic [63:0] ALL_ONES      = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = '0;
   logic [3:0]  req_kind = '0;
   logic [63:0] req_pc = '0;
   logic [63:0] req_fault_address = '0;
   logic [31:0] req_syndrome_in = '0;
   logic [31:0] req_instruction = '0;
   logic [1:0]  req_new_level = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [1:0]  rsp_target_level;
   logic [31:0] rsp_syndrome;
   logic [63:0] rsp_vector_address;
   logic [31:0] rsp_pstate_out;
   logic [63:0] rsp_link_address;
   logic [31:0] rsp_esr_out;
   logic [63:0] rsp_far_out;
   logic [1:0]  rsp_level_out;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   int unsigned errors;
   int unsigned owed;
   int unsigned sent = 0;
   bit          no_idle = 1'b0;

   exception_entry_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_kind           (req_kind),
      .req_pc             (req_pc),
      .req_fault_address  (req_fault_address),
      .req_syndrome_in    (req_syndrome_in),
      .req_instruction    (req_instruction),
      .req_new_level      (req_new_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_target_level   (rsp_target_level),
      .rsp_syndrome       (rsp_syndrome),
      .rsp_vector_address (rsp_vector_address),
      .rsp_pstate_out     (rsp_pstate_out),
      .rsp_link_address   (rsp_link_address),
      .rsp_esr_out        (rsp_esr_out),
      .rsp_far_out        (rsp_far_out),
      .rsp_level_out      (rsp_level_out),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   eeu_checker entry_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_kind           (req_kind),
      .req_pc             (req_pc),
      .req_fault_address  (req_fault_address),
      .req_syndrome_in    (req_syndrome_in),
      .req_instruction    (req_instruction),
      .req_new_level      (req_new_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_target_level   (rsp_target_level),
      .rsp_syndrome       (rsp_syndrome),
      .rsp_vector_address (rsp_vector_address),
      .rsp_pstate_out     (rsp_pstate_out),
      .rsp_link_address   (rsp_link_address),
      .rsp_esr_out        (rsp_esr_out),
      .rsp_far_out        (rsp_far_out),
      .rsp_level_out      (rsp_level_out),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .pready             (pready),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .mismatch_count     (errors),
      .results_owed       (owed)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // one request with a random lead-in gap; returns at its accepting edge
   task automatic send_request(input req_type r);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op <= r.op;
      req_kind <= r.kind;
      req_pc <= r.pc;
      req_fault_address <= r.fault_address;
      req_syndrome_in <= r.syndrome_in;
      req_instruction <= r.instruction;
      req_new_level <= r.new_level;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic issue(input logic [1:0] op, input logic [3:0] kind, input logic [63:0] pc,
                        input logic [63:0] fa, input logic [31:0] syn,
                        input logic [31:0] ins, input logic [1:0] nl);
      req_type r;
      r.op = op;
      r.kind = kind;
      r.pc = pc;
      r.fault_address = fa;
      r.syndrome_in = syn;
      r.instruction = ins;
      r.new_level = nl;
      send_request(r);
   endtask

   // random raise content; instruction often shaped as a load/store
   function automatic req_type rand_fields();
      req_type     r;
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 4))
         0:       r.instruction = raw;
         1:       r.instruction = (raw & ~LDST_PAIR_MASK) | LDST_PAIR_VAL;
         2:       r.instruction = (raw & ~UIMM_MASK) | UIMM_VAL;
         3:       r.instruction = (raw & ~UNSC_MASK) | UNSC_VAL;
         default: r.instruction = (raw & ~UNSC_MASK) | REGOFF_VAL;
      endcase
      r.op = OP_RAISE;
      r.kind = 4'($urandom_range(KIND_UNDEF, KIND_FIQ));
      r.pc = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) r.pc[1:0] = 2'd0;
      r.fault_address = {$urandom, $urandom};
      r.syndrome_in = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      r.new_level = 2'($urandom_range(0, 3));
      return r;
   endfunction

   function automatic req_type noise_fields();
      req_type r;
      r = rand_fields();
      r.op = 2'($urandom_range(0, 3));
      r.kind = 4'($urandom_range(0, 15));
      return r;
   endfunction

   task automatic csr_write(input logic [4:0] addr, input logic [63:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_bases(input logic [63:0] b1, input logic [63:0] b2,
                                input logic [63:0] b3);
      csr_write({CSR_VBAR_EL1, 3'b000}, b1);
      csr_write({CSR_VBAR_EL2, 3'b000}, b2);
      csr_write({CSR_VBAR_EL3, 3'b000}, b3);
   endtask

   // drop valid, let every result drain, then idle before returning
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result side back-pressure
   initial begin : result_sink
      int unsigned stall;
      @(negedge reset);
      @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (psel && penable && pwrite)) quiet = 0;
         else quiet++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      req_type     item;
      int unsigned goal;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      program_bases({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});

      // directed: rejects, routing, the sync, IRQ and FIQ vector slots, syndrome forms
      issue(OP_TAKE, KIND_NONE, '0, '0, '0, '0, 2'd0);           // nothing pending
      issue(OP_RAISE, KIND_NONE, '0, '0, '0, '0, 2'd0);          // no kind
      issue(OP_RAISE, KIND_BAD_LOW, '0, '0, '0, '0, 2'd0);       // kind out of range
      issue(OP_RAISE, KIND_BAD_HIGH, ALL_ONES, ALL_ONES, '0, '0, 2'd3);
      issue(OP_RAISE, KIND_UNDEF, ALL_ONES, ALL_ONES, '0, '0, 2'd0);   // el0 routes to el1
      issue(OP_RAISE, KIND_DABT, 64'h40, 64'h80, '0, '0, 2'd0);  // already pending
      issue(OP_SET_LEVEL, KIND_NONE, '0, '0, '0, '0, 2'd0);      // pending record kept
      issue(OP_TAKE, KIND_NONE, '0, '0, '0, '0, 2'd0);           // lower-level entry
      issue(OP_RAISE, KIND_IABT, 64'h1002, 64'h1002, '0, '0, 2'd0);    // misaligned pc
      issue(OP_TAKE, KIND_NONE, '0, '0, '0, '0, 2'd0);           // same level, spx
      issue(OP_SET_LEVEL, KIND_NONE, '0, '0, '0, '0, 2'd2);
      issue(OP_RAISE, KIND_IRQ, 64'h2000, 64'h5555, '0, '0, 2'd0);     // esr/far unbanked
      issue(OP_TAKE, KIND_NONE, '0, '0, '0, '0, 2'd0);
      issue(OP_SET_LEVEL, KIND_NONE, '0, '0, '0, '0, 2'd3);
      issue(OP_RAISE, KIND_FIQ, 64'h3000, '0, 32'hffff_ffff, '0, 2'd0); // explicit syndrome
      issue(OP_TAKE, KIND_NONE, '0, '0, '0, '0, 2'd0);
      // store pair
      issue(OP_RAISE, KIND_DABT, 64'h4000, ALL_ONES, '0, 32'ha900_7bfd, 2'd0);
      issue(OP_TAKE, KIND_NONE, '0, '0, '0, '0, 2'd0);
      issue(OP_SET_LEVEL, KIND_NONE, '0, '0, '0, '0, 2'd0);
      // unsigned offset load
      issue(OP_RAISE, KIND_ALIGN, 64'h5000, 64'h7, '0, 32'hf940_0000, 2'd0);
      issue(OP_TAKE, KIND_NONE, '0, '0, '0, '0, 2'd0);
      issue(OP_RAISE, KIND_SYSREG, 64'h6000, '0, '0, 32'hffff_ffff, 2'd0);
      issue(OP_TAKE, KIND_NONE, '0, '0, '0, '0, 2'd0);
      issue(OP_UNUSED, KIND_FIQ, ALL_ONES, ALL_ONES, 32'hffff_ffff, 32'hffff_ffff, 2'd3);
      issue(OP_RAISE, KIND_TIMER, 64'h7000, '0, '0, '0, 2'd0);
      issue(OP_TAKE, KIND_NONE, '0, '0, '0, '0, 2'd0);

      // random phases, each under its own vector bases
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0:       program_bases(ALL_ONES, ALL_ONES, ALL_ONES);
            1:       program_bases('0, '0, '0);
            default: program_bases({$urandom, $urandom}, {$urandom, $urandom},
                                   {$urandom, $urandom});
         endcase
         no_idle = (phase == 2);
         goal = sent + RANDOM_ITEMS / PHASES;
         while (sent < goal) begin
            if ($urandom_range(0, 9) < 7) begin
               // raise then take, with an optional level change and noise
               if ($urandom_range(0, 2) == 0) begin
                  item = rand_fields();
                  item.op = OP_SET_LEVEL;
                  send_request(item);
               end
               item = rand_fields();
               send_request(item);
               if ($urandom_range(0, 3) == 0) send_request(noise_fields());
               item = rand_fields();
               item.op = OP_TAKE;
               send_request(item);
            end else begin
               send_request(noise_fields());
            end
         end
      end
      no_idle = 1'b0;
      settle();

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
